FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Simulation builds get the checks, and
// synthesis builds (SYNTH defined) get empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/pedc_pkg.sv
// ----------------------------------------------------------------------------
// pedc_pkg
// Widths, constants and the queue entry type of the pedigree completeness block.
// ----------------------------------------------------------------------------
package pedc_pkg;

    localparam int MAX_INDIVIDUALS_DEF = 1024;
    localparam int MAX_GENERATIONS_DEF = 16;

    localparam int IDX_IN_W   = 11;
    localparam int IND_W      = 10;
    localparam int GEN_OUT_W  = 4;
    localparam int COMP_W     = 17;
    localparam int DEP_W      = 5;
    localparam int MD_W       = 4;
    localparam int IDX_MAX_W  = 16;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [MD_W-1:0]   MAX_DEPTH_RST = 4'd15;
    localparam logic [COMP_W-1:0] ONE_FIXED     = 17'h10000;
    localparam logic              REG_MAX_DEPTH = 1'b0;

    typedef struct packed {
        logic                 ovf;
        logic [IDX_MAX_W-1:0] cur;
        logic [IDX_MAX_W-1:0] sire;
        logic [IDX_MAX_W-1:0] dam;
        logic [DEP_W-1:0]     sd;
        logic [DEP_W-1:0]     dd;
        logic [DEP_W-1:0]     depth;
    } entry_t;

endpackage

FILE: rtl/pedc_if.sv
// ----------------------------------------------------------------------------
// pedc_if
// Valid/ready channel interfaces for input items and result beats.
// ----------------------------------------------------------------------------
interface pedc_in_if import pedc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [IDX_IN_W-1:0] sire_index;
    logic [IDX_IN_W-1:0] dam_index;

    modport source (output valid, output sire_index, output dam_index, input ready);
    modport sink   (input valid, input sire_index, input dam_index, output ready);

endinterface

interface pedc_out_if import pedc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [IND_W-1:0]     individual;
    logic [GEN_OUT_W-1:0] generation;
    logic [COMP_W-1:0]    completeness;
    logic                 last;
    logic                 overflow;

    modport source (output valid, output individual, output generation,
                    output completeness, output last, output overflow, input ready);
    modport sink   (input valid, input individual, input generation,
                    input completeness, input last, input overflow, output ready);

endinterface

FILE: rtl/pedc_ram.sv
// ----------------------------------------------------------------------------
// pedc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pedc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pedc_fifo.sv
// ----------------------------------------------------------------------------
// pedc_fifo
// Short flop-based queue between the classifier and the generation sequencer.
// ----------------------------------------------------------------------------
module pedc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/pedc_front.sv
// ----------------------------------------------------------------------------
// pedc_front
// Accepts items, looks up the parent depths, sets the individual's depth and
// queues one entry per item (or an overflow entry once the table is full).
// ----------------------------------------------------------------------------
module pedc_front import pedc_pkg::*; #(
    parameter int MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF,
    parameter int MAX_GENERATIONS = MAX_GENERATIONS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [MD_W-1:0] max_depth,
    pedc_in_if.sink         item,
    output logic            push,
    output entry_t          entry,
    input  logic            fifo_full
);

    localparam int IDX_W = $clog2(MAX_INDIVIDUALS);
    localparam int CNT_W = $clog2(MAX_INDIVIDUALS + 1);
    localparam int CMP_W = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;

    typedef enum logic {ST_IDLE, ST_LOOKUP} state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [IDX_IN_W-1:0] sire_reg;
    logic [IDX_IN_W-1:0] sire_next;
    logic [IDX_IN_W-1:0] dam_reg;
    logic [IDX_IN_W-1:0] dam_next;

    logic             accept;
    logic [CMP_W-1:0] sire_in_ptr;
    logic [CMP_W-1:0] dam_in_ptr;
    logic [CMP_W-1:0] sire_ptr;
    logic [CMP_W-1:0] dam_ptr;
    logic [CMP_W-1:0] cur_ext;
    logic             sire_known;
    logic             dam_known;
    logic [DEP_W-1:0] sd_rd;
    logic [DEP_W-1:0] dd_rd;
    logic [DEP_W-1:0] sd;
    logic [DEP_W-1:0] dd;
    logic [DEP_W-1:0] deepest;
    logic [DEP_W-1:0] depth_raw;
    logic [DEP_W-1:0] cap;
    logic [DEP_W-1:0] depth;
    logic             table_full;
    logic             dep_we;

    assign item.ready = (state_reg == ST_IDLE) && !fifo_full;
    assign accept     = item.valid && item.ready;

    assign sire_in_ptr = CMP_W'(item.sire_index) - CMP_W'(1);
    assign dam_in_ptr  = CMP_W'(item.dam_index) - CMP_W'(1);
    assign sire_ptr    = CMP_W'(sire_reg) - CMP_W'(1);
    assign dam_ptr     = CMP_W'(dam_reg) - CMP_W'(1);
    assign cur_ext     = CMP_W'(cnt_reg);

    assign sire_known = (sire_reg != '0) && (CMP_W'(sire_reg) <= cur_ext);
    assign dam_known  = (dam_reg != '0) && (CMP_W'(dam_reg) <= cur_ext);
    assign sd         = sire_known ? sd_rd : '0;
    assign dd         = dam_known ? dd_rd : '0;
    assign deepest    = (sd > dd) ? sd : dd;
    assign depth_raw  = deepest + 1'b1;
    assign table_full = (cnt_reg == CNT_W'(MAX_INDIVIDUALS));

    always_comb
    begin
        cap = DEP_W'(max_depth) + 1'b1;
        if (cap > DEP_W'(MAX_GENERATIONS))
        begin
            cap = DEP_W'(MAX_GENERATIONS);
        end
        depth = (depth_raw > cap) ? cap : depth_raw;
    end

    assign dep_we = (state_reg == ST_LOOKUP) && !table_full;
    assign push   = (state_reg == ST_LOOKUP);

    always_comb
    begin
        entry.ovf   = table_full;
        entry.cur   = IDX_MAX_W'(cnt_reg[IDX_W-1:0]);
        entry.sire  = IDX_MAX_W'(sire_ptr[IDX_W-1:0]);
        entry.dam   = IDX_MAX_W'(dam_ptr[IDX_W-1:0]);
        entry.sd    = sd;
        entry.dd    = dd;
        entry.depth = depth;
    end

    pedc_ram #(
        .WIDTH (DEP_W),
        .DEPTH (MAX_INDIVIDUALS)
    ) u_sire_depth (
        .clk   (clk),
        .we    (dep_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (depth),
        .re    (accept),
        .raddr (sire_in_ptr[IDX_W-1:0]),
        .rdata (sd_rd)
    );

    pedc_ram #(
        .WIDTH (DEP_W),
        .DEPTH (MAX_INDIVIDUALS)
    ) u_dam_depth (
        .clk   (clk),
        .we    (dep_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (depth),
        .re    (accept),
        .raddr (dam_in_ptr[IDX_W-1:0]),
        .rdata (dd_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sire_next  = sire_reg;
        dam_next   = dam_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sire_next  = item.sire_index;
                    dam_next   = item.dam_index;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (!table_full)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sire_reg  <= '0;
            dam_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sire_reg  <= sire_next;
            dam_reg   <= dam_next;
        end
    end

endmodule

FILE: rtl/pedc_back.sv
// ----------------------------------------------------------------------------
// pedc_back
// Generation sequencer: reads the parents' rows one generation per cycle unless
// the result beats stall, writes the individual's row and drives the result beats.
// ----------------------------------------------------------------------------
module pedc_back import pedc_pkg::*; #(
    parameter int MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF,
    parameter int MAX_GENERATIONS = MAX_GENERATIONS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  entry,
    input  logic    fifo_empty,
    output logic    pop,
    pedc_out_if.source result
);

    localparam int IDX_W     = $clog2(MAX_INDIVIDUALS);
    localparam int ROW_W     = $clog2(MAX_GENERATIONS);
    localparam int RAM_DEPTH = MAX_INDIVIDUALS * (2 ** ROW_W);
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    logic                 act_reg;
    logic                 act_next;
    entry_t               ent_reg;
    entry_t               ent_next;
    logic [DEP_W-1:0]     g_reg;
    logic [DEP_W-1:0]     g_next;
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [DEP_W-1:0]     s1_gen_reg;
    logic [DEP_W-1:0]     s1_gen_next;
    logic                 s1_last_reg;
    logic                 s1_last_next;
    logic                 s1_ovf_reg;
    logic                 s1_ovf_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [IND_W-1:0]     out_ind_reg;
    logic [IND_W-1:0]     out_ind_next;
    logic [GEN_OUT_W-1:0] out_gen_reg;
    logic [GEN_OUT_W-1:0] out_gen_next;
    logic [COMP_W-1:0]    out_comp_reg;
    logic [COMP_W-1:0]    out_comp_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 out_ovf_reg;
    logic                 out_ovf_next;

    logic              adv;
    logic              issue;
    logic              issue_last;
    logic [DEP_W-1:0]  g_m1;
    logic [ADDR_W-1:0] sire_addr;
    logic [ADDR_W-1:0] dam_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [COMP_W-1:0] sc_rd;
    logic [COMP_W-1:0] dc_rd;
    logic [COMP_W-1:0] sc;
    logic [COMP_W-1:0] dc;
    logic [COMP_W:0]   sum;
    logic [COMP_W-1:0] value;
    logic              comp_we;

    assign adv        = !s1_valid_reg || !out_valid_reg || result.ready;
    assign issue      = act_reg && adv;
    assign issue_last = ent_reg.ovf || ((g_reg + 1'b1) == ent_reg.depth);
    assign pop        = !act_reg && !s1_valid_reg && !fifo_empty;

    assign g_m1      = g_reg - 1'b1;
    assign sire_addr = ADDR_W'({ent_reg.sire[IDX_W-1:0], g_m1[ROW_W-1:0]});
    assign dam_addr  = ADDR_W'({ent_reg.dam[IDX_W-1:0], g_m1[ROW_W-1:0]});
    assign wr_addr   = ADDR_W'({ent_reg.cur[IDX_W-1:0], s1_gen_reg[ROW_W-1:0]});

    assign sc    = (ent_reg.sd >= s1_gen_reg) ? sc_rd : '0;
    assign dc    = (ent_reg.dd >= s1_gen_reg) ? dc_rd : '0;
    assign sum   = {1'b0, sc} + {1'b0, dc};
    assign value = (s1_gen_reg == '0) ? ONE_FIXED : sum[COMP_W:1];

    assign comp_we = adv && s1_valid_reg && !s1_ovf_reg;

    pedc_ram #(
        .WIDTH (COMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_sire_comp (
        .clk   (clk),
        .we    (comp_we),
        .waddr (wr_addr),
        .wdata (value),
        .re    (issue),
        .raddr (sire_addr),
        .rdata (sc_rd)
    );

    pedc_ram #(
        .WIDTH (COMP_W),
        .DEPTH (RAM_DEPTH)
    ) u_dam_comp (
        .clk   (clk),
        .we    (comp_we),
        .waddr (wr_addr),
        .wdata (value),
        .re    (issue),
        .raddr (dam_addr),
        .rdata (dc_rd)
    );

    always_comb
    begin
        act_next       = act_reg;
        ent_next       = ent_reg;
        g_next         = g_reg;
        s1_valid_next  = s1_valid_reg;
        s1_gen_next    = s1_gen_reg;
        s1_last_next   = s1_last_reg;
        s1_ovf_next    = s1_ovf_reg;
        out_valid_next = out_valid_reg;
        out_ind_next   = out_ind_reg;
        out_gen_next   = out_gen_reg;
        out_comp_next  = out_comp_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (pop)
        begin
            act_next = 1'b1;
            ent_next = entry;
            g_next   = '0;
        end

        if (issue)
        begin
            s1_valid_next = 1'b1;
            s1_gen_next   = g_reg;
            s1_last_next  = issue_last;
            s1_ovf_next   = ent_reg.ovf;
            g_next        = g_reg + 1'b1;
            if (issue_last)
            begin
                act_next = 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (adv && s1_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_ind_next   = s1_ovf_reg ? '0 : ent_reg.cur[IND_W-1:0];
            out_gen_next   = s1_ovf_reg ? '0 : s1_gen_reg[GEN_OUT_W-1:0];
            out_comp_next  = s1_ovf_reg ? '0 : value;
            out_last_next  = s1_last_reg;
            out_ovf_next   = s1_ovf_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        g_reg        <= g_next;
        s1_gen_reg   <= s1_gen_next;
        s1_last_reg  <= s1_last_next;
        s1_ovf_reg   <= s1_ovf_next;
        out_ind_reg  <= out_ind_next;
        out_gen_reg  <= out_gen_next;
        out_comp_reg <= out_comp_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.individual   = out_ind_reg;
    assign result.generation   = out_gen_reg;
    assign result.completeness = out_comp_reg;
    assign result.last         = out_last_reg;
    assign result.overflow     = out_ovf_reg;

endmodule

FILE: rtl/pedigree_completeness.sv
// ----------------------------------------------------------------------------
// pedigree_completeness
// Pedigree completeness index: per-generation fraction of known ancestors for
// each individual, computed from the parents' stored rows.
// ----------------------------------------------------------------------------
//  Channel   Dir   Beat contents
//  item      in    sire_index, dam_index (1-based, 0 unknown)
//  result    out   individual, generation, completeness, last, overflow
//  APB       in    max_depth register at byte address 0
//
//  The classifier looks up both parent depths per item and takes no new item
//  while in its lookup state. The generation sequencer does one completeness
//  RAM read and write per generation; an overflow item gives a single beat.
//  Reset is asynchronous and clears control state only; the tables need none.
//  A stalled result holds the sequencer, and a two-entry queue decouples the
//  classifier from it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pedigree_completeness import pedc_pkg::*; #(
    parameter int MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF,
    parameter int MAX_GENERATIONS = MAX_GENERATIONS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    pedc_in_if.sink            item,
    pedc_out_if.source         result
);

    logic [MD_W-1:0] max_depth_reg;
    logic [MD_W-1:0] max_depth_next;
    logic            reg_sel;
    logic            fifo_push;
    logic            fifo_pop;
    logic            fifo_full;
    logic            fifo_empty;
    entry_t          push_entry;
    entry_t          head_entry;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_MAX_DEPTH);

    always_comb
    begin
        max_depth_next = max_depth_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            max_depth_next = pwdata[MD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= MAX_DEPTH_RST;
        end
        else
        begin
            max_depth_reg <= max_depth_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = PDATA_W'(max_depth_reg);
        end
    end

    pedc_front #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .MAX_GENERATIONS (MAX_GENERATIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_depth (max_depth_reg),
        .item      (item),
        .push      (fifo_push),
        .entry     (push_entry),
        .fifo_full (fifo_full)
    );

    pedc_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (2)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (push_entry),
        .pop   (fifo_pop),
        .rdata (head_entry),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    pedc_back #(
        .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
        .MAX_GENERATIONS (MAX_GENERATIONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (head_entry),
        .fifo_empty (fifo_empty),
        .pop        (fifo_pop),
        .result     (result)
    );

    `ASSERT_IMPLY(a_push_has_room, clk, rst_n, fifo_push, !fifo_full)
    `ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, fifo_pop, !fifo_empty)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item.valid && item.ready, !item.ready)
    `ASSERT_IMPLY(a_overflow_beat, clk, rst_n, result.valid && result.overflow, result.last && result.completeness == '0 && result.generation == '0)

endmodule

FILE: sim/tb_pedigree_completeness.sv
// ----------------------------------------------------------------------------
// tb_pedigree_completeness
// Self-checking testbench for the pedigree completeness block. A driver feeds
// parent pairs from a queue, a predictor keeps its own depth and completeness
// tables and queues the expected generation rows, and a monitor checks every
// result beat against them. The run walks through several max_depth settings
// and idling mixes, with parents that are unknown or not earlier than the
// individual mixed in.
// ----------------------------------------------------------------------------
module tb_pedigree_completeness import pedc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                 SETTLE_CYCLES  = 40;
    localparam int                 PHASE_ITEMS    = 36;
    localparam logic [PADDR_W-1:0] MAX_DEPTH_ADDR = PADDR_W'({REG_MAX_DEPTH, 2'b00});

    typedef struct packed {
        logic [IDX_IN_W-1:0] sire;
        logic [IDX_IN_W-1:0] dam;
    } parent_pair_t;

    typedef struct packed {
        logic [IND_W-1:0]     individual;
        logic [GEN_OUT_W-1:0] generation;
        logic [COMP_W-1:0]    completeness;
        logic                 last;
        logic                 overflow;
    } gen_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pedc_in_if  item_bus ();
    pedc_out_if result_bus ();

    pedigree_completeness u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_bus.sink),
        .result  (result_bus.source)
    );

    parent_pair_t     pair_feed [$];
    gen_row_t         rows_due [$];
    parent_pair_t     next_pair;
    gen_row_t         want_row;

    logic [DEP_W-1:0]  known_depth [MAX_INDIVIDUALS_DEF];
    logic [COMP_W-1:0] known_comp [MAX_INDIVIDUALS_DEF][MAX_GENERATIONS_DEF];
    logic [MD_W-1:0]   max_depth_cfg;
    int unsigned       stored_count;
    int unsigned       planned_count;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned fault_count;
    int unsigned rows_checked;
    int unsigned overflow_items;
    int unsigned cfg_writes;
    int unsigned deepest_gen;

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic trace_ancestry(input logic [IDX_IN_W-1:0] sire,
                                  input logic [IDX_IN_W-1:0] dam);
        gen_row_t          row;
        int unsigned       cur;
        int unsigned       sd;
        int unsigned       dd;
        int unsigned       dep;
        int unsigned       cap;
        int unsigned       g;
        logic [COMP_W-1:0] sc;
        logic [COMP_W-1:0] dc;
        logic [COMP_W:0]   sum;
        cur = stored_count;
        if (cur >= MAX_INDIVIDUALS_DEF)
        begin
            row = '{individual: '0, generation: '0, completeness: '0,
                    last: 1'b1, overflow: 1'b1};
            rows_due.push_back(row);
            overflow_items++;
            return;
        end
        sd = (sire == 0 || sire > cur) ? 0 : known_depth[sire - 1];
        dd = (dam == 0 || dam > cur) ? 0 : known_depth[dam - 1];
        dep = 1 + ((sd > dd) ? sd : dd);
        cap = max_depth_cfg + 1;
        if (cap > MAX_GENERATIONS_DEF)
        begin
            cap = MAX_GENERATIONS_DEF;
        end
        if (dep > cap)
        begin
            dep = cap;
        end
        known_depth[cur] = DEP_W'(dep);
        known_comp[cur][0] = ONE_FIXED;
        for (g = 1; g < dep; g++)
        begin
            sc = (sd >= g) ? known_comp[sire - 1][g - 1] : '0;
            dc = (dd >= g) ? known_comp[dam - 1][g - 1] : '0;
            sum = {1'b0, sc} + {1'b0, dc};
            known_comp[cur][g] = sum[COMP_W:1];
        end
        for (g = 0; g < dep; g++)
        begin
            row.individual   = IND_W'(cur);
            row.generation   = GEN_OUT_W'(g);
            row.completeness = known_comp[cur][g];
            row.last         = (g + 1 == dep);
            row.overflow     = 1'b0;
            rows_due.push_back(row);
        end
        stored_count = cur + 1;
    endtask

    function automatic logic [IDX_IN_W-1:0] pick_parent(input int unsigned cur);
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        if (cur == 0 || cur >= MAX_INDIVIDUALS_DEF)
        begin
            return IDX_IN_W'($urandom_range(0, MAX_INDIVIDUALS_DEF));
        end
        span = (cur > 8) ? 7 : cur - 1;
        if (roll < 70)
        begin
            return IDX_IN_W'(cur - $urandom_range(0, span));
        end
        if (roll < 80)
        begin
            return IDX_IN_W'($urandom_range(1, cur));
        end
        if (roll < 88)
        begin
            return '0;
        end
        if (roll < 95)
        begin
            return IDX_IN_W'($urandom_range(cur + 1, MAX_INDIVIDUALS_DEF));
        end
        return IDX_IN_W'(MAX_INDIVIDUALS_DEF);
    endfunction

    task automatic queue_pair(input logic [IDX_IN_W-1:0] sire,
                              input logic [IDX_IN_W-1:0] dam);
        pair_feed.push_back('{sire: sire, dam: dam});
        planned_count++;
    endtask

    task automatic queue_random_pair();
        logic [IDX_IN_W-1:0] sire;
        logic [IDX_IN_W-1:0] dam;
        sire = pick_parent(planned_count);
        dam = pick_parent(planned_count);
        queue_pair(sire, dam);
    endtask

    task automatic drain();
        while (pair_feed.size() != 0 || item_bus.valid || rows_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_depth(input logic [MD_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_DEPTH_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        max_depth_cfg = value;
        cfg_writes++;
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                gap_pct = 54;
                stall_pct = 0;
            end
            2:
            begin
                gap_pct = 0;
                stall_pct = 54;
            end
            default:
            begin
                gap_pct = 18;
                stall_pct = 18;
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                trace_ancestry(item_bus.sire_index, item_bus.dam_index);
            end
            if (!item_bus.valid || item_bus.ready)
            begin
                if (pair_feed.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    next_pair = pair_feed.pop_front();
                    item_bus.valid      <= 1'b1;
                    item_bus.sire_index <= next_pair.sire;
                    item_bus.dam_index  <= next_pair.dam;
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            result_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (result_bus.valid && result_bus.ready)
            begin
                if (rows_due.size() == 0)
                begin
                    note_fault($sformatf(
                        "unexpected result beat: ind %0d gen %0d comp %0d last %0b ovf %0b",
                        result_bus.individual, result_bus.generation,
                        result_bus.completeness, result_bus.last, result_bus.overflow));
                end
                else
                begin
                    want_row = rows_due.pop_front();
                    rows_checked++;
                    if (result_bus.individual !== want_row.individual ||
                        result_bus.generation !== want_row.generation ||
                        result_bus.completeness !== want_row.completeness ||
                        result_bus.last !== want_row.last ||
                        result_bus.overflow !== want_row.overflow)
                    begin
                        note_fault($sformatf(
                            {"result mismatch: expected ind %0d gen %0d comp %0d last %0b ",
                             "ovf %0b, got ind %0d gen %0d comp %0d last %0b ovf %0b"},
                            want_row.individual, want_row.generation,
                            want_row.completeness, want_row.last, want_row.overflow,
                            result_bus.individual, result_bus.generation,
                            result_bus.completeness, result_bus.last,
                            result_bus.overflow));
                    end
                    if (!want_row.overflow && want_row.generation > deepest_gen)
                    begin
                        deepest_gen = want_row.generation;
                    end
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Timed out with %0d result beats still outstanding.", rows_due.size());
        $display("FAIL pedigree_completeness");
        $finish;
    end

    initial
    begin
        logic [MD_W-1:0] phase_depth [7];
        int unsigned     p;
        int unsigned     i;
        int unsigned     cur;
        phase_depth = '{4'd15, 4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd15};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_bus.valid = 1'b0;
        item_bus.sire_index = '0;
        item_bus.dam_index = '0;
        result_bus.ready = 1'b0;
        max_depth_cfg = MAX_DEPTH_RST;
        stored_count = 0;
        planned_count = 0;
        fault_count = 0;
        rows_checked = 0;
        overflow_items = 0;
        cfg_writes = 0;
        deepest_gen = 0;
        set_idling(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Founders, self and later parents, then a chain that reaches the cap.
        queue_pair('0, '0);
        queue_pair(11'd2, 11'd1024);
        queue_pair(11'd1, 11'd2);
        queue_pair(11'd3, '0);
        queue_pair('0, 11'd4);
        for (cur = 5; cur < 18; cur++)
        begin
            queue_pair(IDX_IN_W'(cur), IDX_IN_W'(cur - 1));
        end
        queue_pair(11'd19, 11'd1);
        queue_pair(11'd1024, '0);
        drain();

        for (p = 0; p < 7; p++)
        begin
            set_idling(p % 4);
            write_max_depth(phase_depth[p]);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                queue_random_pair();
            end
            drain();
        end

        set_idling(2);
        write_max_depth(4'd15);
        queue_pair(11'd1024, 11'd1024);
        queue_pair('0, '0);
        for (i = 0; i < 8; i++)
        begin
            queue_random_pair();
        end
        drain();

        if (rows_due.size() != 0)
        begin
            note_fault($sformatf("%0d expected result beats never arrived", rows_due.size()));
        end
        $display("Run covered %0d stored individuals and %0d table-full items under %0d writes",
                 stored_count, overflow_items, cfg_writes);
        $display("of max_depth; %0d result beats checked, deepest generation %0d, %0d faults.",
                 rows_checked, deepest_gen, fault_count);
        if (fault_count == 0)
        begin
            $display("PASS pedigree_completeness");
        end
        else
        begin
            $display("FAIL pedigree_completeness");
        end
        $finish;
    end

endmodule
